/* sv/rlfs_pkg.sv */
package rlfs_pkg;

   localparam int MAX_LINKS      = 4;
   localparam int GROUP_BITS     = 8;
   localparam int LINK_BITS      = $clog2(MAX_LINKS);
   localparam int COUNT_BITS     = 3;
   localparam int LINK_ID_BITS   = 8;
   localparam int GROUPS_WIDTH   = 32;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 32;

   typedef enum logic [2:0] {
      CAUSE_DISCONNECT    = 3'd0,
      CAUSE_CONNECT       = 3'd1,
      CAUSE_SLAVE2MASTER  = 3'd2,
      CAUSE_MASTER2SLAVE  = 3'd3,
      CAUSE_TO_MONITOR    = 3'd4,
      CAUSE_TO_CONTROLLER = 3'd5,
      CAUSE_REQ_NORMAL    = 3'd6,
      CAUSE_REQ_STANDBY   = 3'd7
   } cause_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_LINK  = 2'd1,
      STATUS_BAD_LINK = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      MODE_CMD_NONE    = 2'd0,
      MODE_CMD_NORMAL  = 2'd1,
      MODE_CMD_STANDBY = 2'd2
   } mode_cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_LINK_COUNT  = 1'b0,
      REG_LINK_GROUPS = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]   links_in_use;
      logic [GROUPS_WIDTH-1:0] groups;
   } csr_type;

   typedef struct packed {
      status_type              status;
      logic [LINK_BITS-1:0]    active_next;
      logic                    switched;
      mode_cmd_type            mode_cmd;
      cause_type               change_cause;
      logic                    normal_next;
      logic [GROUP_BITS-1:0]   active_group;
      logic [GROUP_BITS-1:0]   previous_group;
   } decision_type;

   function automatic logic [GROUP_BITS-1:0] group_of(
      input logic [GROUPS_WIDTH-1:0] groups,
      input logic [LINK_BITS-1:0]    idx
   );
      return groups[idx*GROUP_BITS +: GROUP_BITS];
   endfunction

endpackage

/* sv/rlfs_csr.sv */
module rlfs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [rlfs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rlfs_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   output rlfs_pkg::csr_type                   cfg
);

   logic [rlfs_pkg::COUNT_BITS-1:0]   link_count_ff, link_count_in;
   logic [rlfs_pkg::GROUPS_WIDTH-1:0] link_groups_ff, link_groups_in;

   always_comb begin
      link_count_in  = link_count_ff;
      link_groups_in = link_groups_ff;
      if (csr_write_enable) begin
         unique case (rlfs_pkg::reg_index_type'(csr_index))
            rlfs_pkg::REG_LINK_COUNT: begin
               link_count_in = csr_write_data[rlfs_pkg::COUNT_BITS-1:0];
            end
            rlfs_pkg::REG_LINK_GROUPS: begin
               link_groups_in = csr_write_data[rlfs_pkg::GROUPS_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_count_ff  <= rlfs_pkg::COUNT_BITS'(1);
         link_groups_ff <= '0;
      end else begin
         link_count_ff  <= link_count_in;
         link_groups_ff <= link_groups_in;
      end
   end

   // A count of zero means one link; anything above the link limit is clamped.
   always_comb begin
      cfg.groups = link_groups_ff;
      priority if (link_count_ff == '0) begin
         cfg.links_in_use = rlfs_pkg::COUNT_BITS'(1);
      end else if (link_count_ff > rlfs_pkg::COUNT_BITS'(rlfs_pkg::MAX_LINKS)) begin
         cfg.links_in_use = rlfs_pkg::COUNT_BITS'(rlfs_pkg::MAX_LINKS);
      end else begin
         cfg.links_in_use = link_count_ff;
      end
   end

endmodule

/* sv/rlfs_select.sv */
module rlfs_select (
   input  rlfs_pkg::csr_type                     cfg,
   input  rlfs_pkg::cause_type                   cause,
   input  logic [rlfs_pkg::LINK_ID_BITS-1:0]     event_link,
   input  logic [rlfs_pkg::GROUP_BITS-1:0]       event_group,
   input  logic [rlfs_pkg::MAX_LINKS-1:0]        connected_mask,
   input  logic [rlfs_pkg::LINK_BITS-1:0]        active_index,
   input  logic                                  normal_mode,
   output rlfs_pkg::decision_type                decision
);

   localparam int LB = rlfs_pkg::LINK_BITS;

   logic [rlfs_pkg::GROUP_BITS-1:0] agrp, gi;
   logic                            aconn, in_use;
   logic                            same_found, diff_found, eq_found, ne_found, conn_found;
   logic [LB-1:0]                   same_idx, diff_idx, eq_idx, ne_idx, conn_idx;
   logic                            act, pick_valid;
   logic [LB-1:0]                   pick_idx;
   rlfs_pkg::cause_type             eff_cause;

   // All priority scans run side by side over the links in use.
   always_comb begin
      agrp       = rlfs_pkg::group_of(cfg.groups, active_index);
      aconn      = connected_mask[active_index];
      gi         = '0;
      in_use     = 1'b0;
      same_found = 1'b0;
      diff_found = 1'b0;
      eq_found   = 1'b0;
      ne_found   = 1'b0;
      conn_found = 1'b0;
      same_idx   = '0;
      diff_idx   = '0;
      eq_idx     = '0;
      ne_idx     = '0;
      conn_idx   = '0;
      for (int i = 0; i < rlfs_pkg::MAX_LINKS; i++) begin
         in_use = rlfs_pkg::COUNT_BITS'(i) < cfg.links_in_use;
         gi     = rlfs_pkg::group_of(cfg.groups, LB'(i));
         if (in_use && connected_mask[i]) begin
            // The same-group scan keeps the last match.
            if (gi == agrp && LB'(i) != active_index) begin
               same_found = 1'b1;
               same_idx   = LB'(i);
            end
            if (gi != agrp && LB'(i) != active_index && !diff_found) begin
               diff_found = 1'b1;
               diff_idx   = LB'(i);
            end
            if (gi == event_group && !eq_found) begin
               eq_found = 1'b1;
               eq_idx   = LB'(i);
            end
            if (gi != event_group && !ne_found) begin
               ne_found = 1'b1;
               ne_idx   = LB'(i);
            end
            if (!conn_found) begin
               conn_found = 1'b1;
               conn_idx   = LB'(i);
            end
         end
      end
   end

   always_comb begin
      act                  = 1'b1;
      eff_cause            = cause;
      pick_valid           = 1'b0;
      pick_idx             = '0;
      decision.status      = rlfs_pkg::STATUS_OK;
      decision.mode_cmd    = rlfs_pkg::MODE_CMD_NONE;
      decision.normal_next = normal_mode;

      // Mode requests change the mode first and then act like the queued
      // mode message; a request for the mode already held does nothing.
      if (cause == rlfs_pkg::CAUSE_REQ_NORMAL) begin
         if (normal_mode) begin
            act = 1'b0;
         end else begin
            decision.normal_next = 1'b1;
            eff_cause            = rlfs_pkg::CAUSE_TO_CONTROLLER;
         end
      end else if (cause == rlfs_pkg::CAUSE_REQ_STANDBY) begin
         if (!normal_mode) begin
            act = 1'b0;
         end else begin
            decision.normal_next = 1'b0;
            eff_cause            = rlfs_pkg::CAUSE_TO_MONITOR;
         end
      end

      if (act) begin
         if (!decision.normal_next) begin
            decision.mode_cmd = rlfs_pkg::MODE_CMD_STANDBY;
         end else begin
            unique case (eff_cause)
               rlfs_pkg::CAUSE_DISCONNECT: begin
                  if (cfg.links_in_use == rlfs_pkg::COUNT_BITS'(1)) begin
                     decision.mode_cmd = rlfs_pkg::MODE_CMD_NORMAL;
                  end else if (same_found) begin
                     pick_valid = 1'b1;
                     pick_idx   = same_idx;
                  end else if (diff_found) begin
                     pick_valid = 1'b1;
                     pick_idx   = diff_idx;
                  end else begin
                     decision.status = rlfs_pkg::STATUS_NO_LINK;
                  end
               end
               rlfs_pkg::CAUSE_CONNECT: begin
                  if (aconn) begin
                     decision.mode_cmd = rlfs_pkg::MODE_CMD_NORMAL;
                  end else if (event_link >= rlfs_pkg::LINK_ID_BITS'(cfg.links_in_use)) begin
                     decision.status = rlfs_pkg::STATUS_BAD_LINK;
                  end else begin
                     pick_valid = 1'b1;
                     pick_idx   = event_link[LB-1:0];
                  end
               end
               rlfs_pkg::CAUSE_SLAVE2MASTER: begin
                  if (!(event_group == agrp && aconn)) begin
                     if (eq_found) begin
                        pick_valid = 1'b1;
                        pick_idx   = eq_idx;
                     end else begin
                        decision.status = rlfs_pkg::STATUS_NO_LINK;
                     end
                  end
               end
               rlfs_pkg::CAUSE_MASTER2SLAVE: begin
                  if (!(event_group != agrp && aconn)) begin
                     if (ne_found) begin
                        pick_valid = 1'b1;
                        pick_idx   = ne_idx;
                     end else begin
                        decision.status = rlfs_pkg::STATUS_NO_LINK;
                     end
                  end
               end
               rlfs_pkg::CAUSE_TO_MONITOR: begin
                  decision.mode_cmd = rlfs_pkg::MODE_CMD_STANDBY;
               end
               rlfs_pkg::CAUSE_TO_CONTROLLER: begin
                  if (conn_found) begin
                     pick_valid = 1'b1;
                     pick_idx   = conn_idx;
                  end else begin
                     decision.status = rlfs_pkg::STATUS_NO_LINK;
                  end
               end
               rlfs_pkg::CAUSE_REQ_NORMAL, rlfs_pkg::CAUSE_REQ_STANDBY: begin
               end
               default: begin
               end
            endcase
         end
      end

      decision.switched     = pick_valid;
      decision.change_cause = rlfs_pkg::CAUSE_DISCONNECT;
      decision.active_next  = active_index;
      if (pick_valid) begin
         decision.active_next  = pick_idx;
         decision.mode_cmd     = rlfs_pkg::MODE_CMD_NORMAL;
         decision.change_cause = eff_cause;
      end
      decision.active_group   = rlfs_pkg::group_of(cfg.groups, decision.active_next);
      decision.previous_group = rlfs_pkg::group_of(cfg.groups, active_index);
   end

endmodule

/* sv/redundant_link_failover_selector.sv */
// An accepted item is held in the input register; its result is then registered
// in the result register and shown on rsp_valid. Throughput: one item per cycle
// while rsp_stall is low; the input register and the result register let a new
// item in while a finished result still waits to be taken.
// Reset: synchronous, active high; active link 0, standby mode, link count 1,
// all link groups 0, both pipeline registers empty.
module redundant_link_failover_selector (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_cause,
   input  logic [rlfs_pkg::LINK_ID_BITS-1:0]   req_event_link,
   input  logic [rlfs_pkg::GROUP_BITS-1:0]     req_event_group,
   input  logic [rlfs_pkg::MAX_LINKS-1:0]      req_connected_mask,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [rlfs_pkg::LINK_BITS-1:0]      rsp_active_link,
   output logic                                rsp_switched,
   output logic [rlfs_pkg::LINK_BITS-1:0]      rsp_previous_link,
   output logic [rlfs_pkg::GROUP_BITS-1:0]     rsp_active_group,
   output logic [rlfs_pkg::GROUP_BITS-1:0]     rsp_previous_group,
   output logic [1:0]                          rsp_mode_command,
   output logic [2:0]                          rsp_change_cause,
   input  logic                                csr_write_enable,
   input  logic [rlfs_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rlfs_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   rlfs_pkg::csr_type      cfg;
   rlfs_pkg::decision_type decision;

   logic                                  in_valid_ff, in_valid_in;
   rlfs_pkg::cause_type                   cause_ff, cause_in;
   logic [rlfs_pkg::LINK_ID_BITS-1:0]     event_link_ff, event_link_in;
   logic [rlfs_pkg::GROUP_BITS-1:0]       event_group_ff, event_group_in;
   logic [rlfs_pkg::MAX_LINKS-1:0]        mask_ff, mask_in;

   logic [rlfs_pkg::LINK_BITS-1:0]        active_index_ff, active_index_in;
   logic                                  normal_mode_ff, normal_mode_in;

   logic                                  rsp_valid_ff, rsp_valid_in;
   rlfs_pkg::decision_type                result_ff, result_in;
   logic [rlfs_pkg::LINK_BITS-1:0]        prev_link_ff, prev_link_in;

   logic out_free, advance, accept;

   rlfs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   rlfs_select u_select (
      .cfg            (cfg),
      .cause          (cause_ff),
      .event_link     (event_link_ff),
      .event_group    (event_group_ff),
      .connected_mask (mask_ff),
      .active_index   (active_index_ff),
      .normal_mode    (normal_mode_ff),
      .decision       (decision)
   );

   // The held item moves on whenever the result register is empty or being emptied.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in     = accept || (in_valid_ff && !advance);
      cause_in        = cause_ff;
      event_link_in   = event_link_ff;
      event_group_in  = event_group_ff;
      mask_in         = mask_ff;
      if (accept) begin
         cause_in       = rlfs_pkg::cause_type'(req_cause);
         event_link_in  = req_event_link;
         event_group_in = req_event_group;
         mask_in        = req_connected_mask;
      end

      rsp_valid_in    = advance || (rsp_valid_ff && rsp_stall);
      active_index_in = active_index_ff;
      normal_mode_in  = normal_mode_ff;
      result_in       = result_ff;
      prev_link_in    = prev_link_ff;
      if (advance) begin
         active_index_in = decision.active_next;
         normal_mode_in  = decision.normal_next;
         result_in       = decision;
         prev_link_in    = active_index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         active_index_ff <= '0;
         normal_mode_ff  <= 1'b0;
      end else begin
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         active_index_ff <= active_index_in;
         normal_mode_ff  <= normal_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      cause_ff       <= cause_in;
      event_link_ff  <= event_link_in;
      event_group_ff <= event_group_in;
      mask_ff        <= mask_in;
      result_ff      <= result_in;
      prev_link_ff   <= prev_link_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = result_ff.status;
   assign rsp_active_link    = result_ff.active_next;
   assign rsp_switched       = result_ff.switched;
   assign rsp_previous_link  = prev_link_ff;
   assign rsp_active_group   = result_ff.active_group;
   assign rsp_previous_group = result_ff.previous_group;
   assign rsp_mode_command   = result_ff.mode_cmd;
   assign rsp_change_cause   = result_ff.change_cause;

   // A changeover always orders the new link normal.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.switched |-> result_ff.mode_cmd == rlfs_pkg::MODE_CMD_NORMAL)
      else $error("changeover without normal command");

   // A failed event leaves the active link where it was.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.status != rlfs_pkg::STATUS_OK
      |-> !result_ff.switched && result_ff.active_next == prev_link_ff)
      else $error("active link moved on a failed event");

   // The state register follows the result of each item that moves on.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> active_index_ff == result_ff.active_next
                  && normal_mode_ff == result_ff.normal_next)
      else $error("state does not match delivered result");

   // The previous link of a result is the active link of the result before it.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> prev_link_ff == $past(active_index_ff))
      else $error("previous link mismatch");

   // A change cause is reported only with a changeover.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !result_ff.switched
      |-> result_ff.change_cause == rlfs_pkg::CAUSE_DISCONNECT)
      else $error("change cause without changeover");

endmodule
